/* hw/rtl/nobt_pkg.sv */
// ----------------------------------------------------------------------------
// Oscillator beat tracker package
// Shared types, codes, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package nobt_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        OP_ONSET = 2'd0,
        OP_TICK  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_RESET = 2'd3
    } nobt_op_t;

    // Configuration register indexes
    localparam logic [3:0] CFG_INIT_PERIOD = 4'd0;
    localparam logic [3:0] CFG_FIELD_WIDTH = 4'd1;
    localparam logic [3:0] CFG_PHASE_GAIN  = 4'd2;
    localparam logic [3:0] CFG_PERIOD_GAIN = 4'd3;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_PH_GO, ST_PH_WAIT, ST_CR_GO, ST_CR_WAIT,
        ST_T1, ST_T2, ST_T3, ST_Z1, ST_Z2, ST_EM, ST_ED_GO, ST_ED_WAIT,
        ST_EX, ST_Q_GO, ST_Q_WAIT, ST_S_GO, ST_S_WAIT, ST_F1, ST_F2, ST_F3,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_EMIT
    } nobt_state_t;

    // Period limits, ms * 1024
    localparam logic [22:0] PERIOD_MIN   = 23'd204800;
    localparam logic [22:0] PERIOD_MAX   = 23'd6144000;
    localparam logic [22:0] PERIOD_RESET = 23'd1024000;

    // Fixed-point constants
    localparam logic [29:0] LOG2E_X2_Q16 = 30'd189096;     // 2 * log2(e)
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [29:0] INV2PI_Q16   = 30'd10430;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032875;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;

    // Shared unit widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 30;
    localparam int DIV_W   = 64;
    localparam int DVS_W   = 32;

    // Arctangent of 2^-i, angle units of 2^22 per quarter cycle
    function automatic logic signed [23:0] atan_step(input logic [3:0] i);
        logic signed [23:0] a;
        unique case (i)
            4'd0:  a = 24'sd2097152;
            4'd1:  a = 24'sd1238021;
            4'd2:  a = 24'sd654136;
            4'd3:  a = 24'sd332050;
            4'd4:  a = 24'sd166669;
            4'd5:  a = 24'sd83416;
            4'd6:  a = 24'sd41718;
            4'd7:  a = 24'sd20860;
            4'd8:  a = 24'sd10430;
            4'd9:  a = 24'sd5215;
            4'd10: a = 24'sd2608;
            4'd11: a = 24'sd1304;
            4'd12: a = 24'sd652;
            4'd13: a = 24'sd326;
            4'd14: a = 24'sd163;
            default: a = 24'sd81;
        endcase
        return a;
    endfunction

    // Reciprocal of a series term index, 2^33 / n rounded up; exact floor
    // division for dividends below 2^30. The tenth term takes the default.
    function automatic logic [33:0] recip_index(input logic [3:0] n);
        logic [33:0] r;
        unique case (n)
            4'd1:  r = 34'd8589934592;
            4'd2:  r = 34'd4294967296;
            4'd3:  r = 34'd2863311531;
            4'd4:  r = 34'd2147483648;
            4'd5:  r = 34'd1717986919;
            4'd6:  r = 34'd1431655766;
            4'd7:  r = 34'd1227133514;
            4'd8:  r = 34'd1073741824;
            4'd9:  r = 34'd954437177;
            default: r = 34'd858993460;
        endcase
        return r;
    endfunction

    // Round Q30 to Q16 and clamp to +-1.0
    function automatic logic signed [17:0] q30_to_q16(input logic signed [33:0] v);
        logic signed [34:0] s;
        logic signed [20:0] r;
        logic signed [17:0] q;
        s = 35'(v) + 35'sd8192;
        r = s[34:14];
        if (r > 21'sd65536) begin
            q = 18'sd65536;
        end else if (r < -21'sd65536) begin
            q = -18'sd65536;
        end else begin
            q = r[17:0];
        end
        return q;
    endfunction

    // Clamp a period to its legal range
    function automatic logic [22:0] clamp_period(input logic [24:0] p);
        logic [22:0] c;
        if (p < 25'(PERIOD_MIN)) begin
            c = PERIOD_MIN;
        end else if (p > 25'(PERIOD_MAX)) begin
            c = PERIOD_MAX;
        end else begin
            c = p[22:0];
        end
        return c;
    endfunction

endpackage

/* hw/rtl/nobt_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module nobt_mul
    import nobt_pkg::*;
(
    input  logic                       aclk,
    input  logic [MUL_A_W-1:0]         a,
    input  logic [MUL_B_W-1:0]         b,
    output logic [MUL_A_W+MUL_B_W-1:0] p
);

    logic [MUL_A_W+MUL_B_W-1:0] p_reg;

    // Register the product
    always_ff @(posedge aclk) begin
        p_reg <= (MUL_A_W+MUL_B_W)'(a) * (MUL_A_W+MUL_B_W)'(b);
    end

    assign p = p_reg;

endmodule

/* hw/rtl/nobt_div.sv */
// ----------------------------------------------------------------------------
// Shared divider
// Restoring divider, one quotient bit per cycle. The dividend comes in left
// aligned; after count steps the low count bits of quotient hold the result.
// ----------------------------------------------------------------------------
module nobt_div
    import nobt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    input  logic [5:0]       count,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] diff;
    logic             ge;

    // Trial subtract
    always_comb begin
        shifted = {rem_reg, dvd_reg[DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b0, dvs_reg};
        ge      = ~diff[DVS_W+1];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* hw/rtl/nobt_cordic.sv */
// ----------------------------------------------------------------------------
// Rotation CORDIC
// Sixteen iterations in Q30, one a cycle, for an angle within a quadrant.
// ----------------------------------------------------------------------------
module nobt_cordic
    import nobt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [23:0] angle,
    output logic               done,
    output logic signed [33:0] cos_q30,
    output logic signed [33:0] sin_q30
);

    logic               busy_reg;
    logic               done_reg;
    logic [3:0]         iter_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [23:0] z_reg;
    logic signed [33:0] sx;
    logic signed [33:0] sy;

    assign sx = x_reg >>> iter_reg;
    assign sy = y_reg >>> iter_reg;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 4'd1;
                if (iter_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= CORDIC_X0;
            y_reg <= '0;
            z_reg <= angle;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - atan_step(iter_reg);
            end else begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + atan_step(iter_reg);
            end
        end
    end

    assign done    = done_reg;
    assign cos_q30 = x_reg;
    assign sin_q30 = y_reg;

endmodule

/* hw/rtl/nonlinear_oscillator_beat_tracker.sv */
// ----------------------------------------------------------------------------
// Nonlinear oscillator beat tracker
// Tracks beat phase and period from onset events and refresh ticks.
// ----------------------------------------------------------------------------
// One item at a time. A load or reset item goes straight to the emit step, a
// first tick only starts the timer, a refresh tick runs a 58-step phase
// division on the shared divider, and an onset runs the phase division, 16
// CORDIC iterations, ten series terms with the division by the term index
// done as a multiply by its reciprocal, and 49- and 48-step divisions for
// sech^2, all but the CORDIC on one multiplier and one bit-serial divider.
// The next item is taken while a result waits on the output register; a
// result still waiting there holds the emit step of the following item.
// Configuration writes are taken at any time.
module nonlinear_oscillator_beat_tracker
    import nobt_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [31:0] time_ms, [55:32] new_period
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] phase_out, [38:16] period_out, [39] pulse
    output logic        m_tuser,   // [0] period_valid
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    // Phase rounding before the trig step
    localparam int          RND_STEP = 16 - TRIG_TABLE_BITS;
    localparam logic [15:0] RND_HALF = 16'(1 << (RND_STEP - 1));
    localparam logic [15:0] RND_MASK = 16'(32'hFFFF << RND_STEP);

    nobt_state_t state_reg, state_next;

    // Configuration
    logic [22:0] init_period_reg;
    logic [11:0] field_width_reg;
    logic [8:0]  phase_gain_reg;
    logic [8:0]  period_gain_reg;

    // Oscillator state
    logic [15:0] osc_phase_reg;
    logic [22:0] osc_period_reg;
    logic [31:0] last_time_reg;
    logic        timer_started_reg;

    // Item and work registers
    logic [1:0]         op_reg;
    logic [31:0]        time_reg;
    logic [23:0]        np_reg;
    logic [15:0]        before_reg;
    logic               valid_reg;
    logic               pulse_en_reg;
    logic [1:0]         quad_reg;
    logic [17:0]        m_reg;
    logic [16:0]        smag_reg;
    logic               neg_reg;
    logic [23:0]        t_reg;
    logic [29:0]        z_reg;
    logic [30:0]        term_reg;
    logic signed [32:0] sum_reg;
    logic [3:0]         n_reg;
    logic [30:0]        u_reg;
    logic [31:0]        d_reg;
    logic [17:0]        q_reg;
    logic [16:0]        sech_reg;
    logic [15:0]        fmag_reg;
    logic [15:0]        dp1_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tuser_reg;

    // Shared units
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] mul_p;
    logic                       div_start;
    logic [DIV_W-1:0]           div_dividend;
    logic [DVS_W-1:0]           div_divisor;
    logic [5:0]                 div_count;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quot;
    logic                       cr_start;
    logic signed [23:0]         cr_angle;
    logic                       cr_done;
    logic signed [33:0]         cr_cos;
    logic signed [33:0]         cr_sin;

    // Misc combinational
    logic        in_accept;
    logic        out_free;
    logic [31:0] dt;
    logic [15:0] ph_rnd;
    logic signed [17:0] s_q16;
    logic signed [17:0] c_q16;
    logic signed [17:0] sin_v;
    logic signed [17:0] cos_v;
    logic [30:0] sum_c;
    logic [48:0] t_sum;
    logic [47:0] f_sum;
    logic [23:0] p2_sum;
    logic [47:0] p4_sum;
    logic [23:0] dp2;
    logic [22:0] period_adj;
    logic signed [15:0] after;
    logic        pulse;
    logic [29:0] term_q;

    nobt_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    nobt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .count    (div_count),
        .done     (div_done),
        .quotient (div_quot)
    );

    nobt_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cr_start),
        .angle   (cr_angle),
        .done    (cr_done),
        .cos_q30 (cr_cos),
        .sin_q30 (cr_sin)
    );

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Datapath helpers
    always_comb begin
        dt     = time_reg - last_time_reg;
        ph_rnd = (osc_phase_reg + RND_HALF) & RND_MASK;
        c_q16  = q30_to_q16(cr_cos);
        s_q16  = q30_to_q16(cr_sin);
        unique case (quad_reg)
            2'd0: begin sin_v = s_q16;  cos_v = c_q16;  end
            2'd1: begin sin_v = c_q16;  cos_v = -s_q16; end
            2'd2: begin sin_v = -s_q16; cos_v = -c_q16; end
            default: begin sin_v = -c_q16; cos_v = s_q16; end
        endcase
        sum_c  = sum_reg[32] ? 31'd0 : sum_reg[30:0];
        term_q = mul_p[62:33];
        t_sum  = mul_p[48:0] + 49'h80_0000;
        f_sum  = mul_p[47:0] + 48'h8000_0000;
        p2_sum = mul_p[23:0] + 24'd128;
        p4_sum = mul_p[47:0] + 48'h80_0000;
        dp2    = p4_sum[47:24];
        if (neg_reg) begin
            if ({1'b0, dp2} >= {2'b0, osc_period_reg}) begin
                period_adj = PERIOD_MIN;
            end else begin
                period_adj = clamp_period({2'b0, osc_period_reg} - {1'b0, dp2});
            end
        end else begin
            period_adj = clamp_period({2'b0, osc_period_reg} + {1'b0, dp2});
        end
        after = osc_phase_reg;
        pulse = pulse_en_reg && ((after == 16'sd0) ||
                (before_reg[15] && !after[15]));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_accept) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                priority if (op_reg == OP_LOAD || op_reg == OP_RESET) begin
                    state_next = ST_EMIT;
                end else if (op_reg == OP_TICK && !timer_started_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_PH_GO;
                end
            end
            ST_PH_GO:    state_next = ST_PH_WAIT;
            ST_PH_WAIT:  if (div_done) state_next = (op_reg == OP_ONSET) ? ST_CR_GO : ST_EMIT;
            ST_CR_GO:    state_next = ST_CR_WAIT;
            ST_CR_WAIT:  if (cr_done) state_next = ST_T1;
            ST_T1:       state_next = ST_T2;
            ST_T2:       state_next = ST_T3;
            ST_T3:       state_next = ST_Z1;
            ST_Z1:       state_next = ST_Z2;
            ST_Z2:       state_next = ST_EM;
            ST_EM:       state_next = ST_ED_GO;
            ST_ED_GO:    state_next = ST_ED_WAIT;
            ST_ED_WAIT:  state_next = (n_reg == 4'd10) ? ST_EX : ST_EM;
            ST_EX:       state_next = ST_Q_GO;
            ST_Q_GO:     state_next = ST_Q_WAIT;
            ST_Q_WAIT:   if (div_done) state_next = ST_S_GO;
            ST_S_GO:     state_next = ST_S_WAIT;
            ST_S_WAIT:   if (div_done) state_next = ST_F1;
            ST_F1:       state_next = ST_F2;
            ST_F2:       state_next = ST_F3;
            ST_F3:       state_next = ST_P1;
            ST_P1:       state_next = ST_P2;
            ST_P2:       state_next = ST_P3;
            ST_P3:       state_next = ST_P4;
            ST_P4:       state_next = ST_EMIT;
            ST_EMIT:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Unit controls
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_count    = '0;
        cr_start     = 1'b0;
        cr_angle     = {2'b0, ph_rnd[13:0], 8'b0};
        unique case (state_reg)
            ST_PH_GO: begin
                div_start    = 1'b1;
                div_dividend = {dt, 4'b0, osc_period_reg[22:1], 6'b0};
                div_divisor  = {9'b0, osc_period_reg};
                div_count    = 6'd58;
            end
            ST_CR_GO: cr_start = 1'b1;
            ST_T1: begin
                mul_a = MUL_A_W'(field_width_reg);
                mul_b = MUL_B_W'(m_reg);
            end
            ST_T2: begin
                mul_a = mul_p[MUL_A_W-1:0];
                mul_b = LOG2E_X2_Q16;
            end
            ST_Z1: begin
                mul_a = MUL_A_W'(t_reg[15:0]);
                mul_b = LN2_Q30;
            end
            ST_EM: begin
                mul_a = MUL_A_W'(term_reg);
                mul_b = z_reg;
            end
            // Divide the scaled term by its index through the reciprocal
            ST_ED_GO: begin
                mul_a = recip_index(n_reg);
                mul_b = mul_p[59:30];
            end
            ST_Q_GO: begin
                div_start    = 1'b1;
                div_dividend = {u_reg, 33'b0};
                div_divisor  = d_reg;
                div_count    = 6'd49;
            end
            ST_S_GO: begin
                div_start    = 1'b1;
                div_dividend = {q_reg, 46'b0};
                div_divisor  = d_reg;
                div_count    = 6'd48;
            end
            ST_F1: begin
                mul_a = MUL_A_W'(smag_reg);
                mul_b = MUL_B_W'(sech_reg);
            end
            ST_F2: begin
                mul_a = mul_p[MUL_A_W-1:0];
                mul_b = INV2PI_Q16;
            end
            ST_P1: begin
                mul_a = MUL_A_W'(phase_gain_reg);
                mul_b = MUL_B_W'(fmag_reg);
            end
            ST_P2: begin
                mul_a = MUL_A_W'(osc_period_reg);
                mul_b = MUL_B_W'(period_gain_reg);
            end
            ST_P3: begin
                mul_a = mul_p[MUL_A_W-1:0];
                mul_b = MUL_B_W'(fmag_reg);
            end
            default: ;
        endcase
    end

    // Control state, configuration and oscillator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            init_period_reg   <= PERIOD_RESET;
            field_width_reg   <= '0;
            phase_gain_reg    <= '0;
            period_gain_reg   <= '0;
            osc_phase_reg     <= '0;
            osc_period_reg    <= PERIOD_RESET;
            last_time_reg     <= '0;
            timer_started_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Take configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_INIT_PERIOD: init_period_reg <= cfg_data;
                    CFG_FIELD_WIDTH: field_width_reg <= cfg_data[11:0];
                    CFG_PHASE_GAIN:  phase_gain_reg  <= cfg_data[8:0];
                    CFG_PERIOD_GAIN: period_gain_reg <= cfg_data[8:0];
                    default: ;
                endcase
            end

            // Raise a new result, or drop the current one once taken
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_DISPATCH: begin
                    priority if (op_reg == OP_LOAD) begin
                        osc_period_reg <= clamp_period({1'b0, np_reg});
                        osc_phase_reg  <= '0;
                    end else if (op_reg == OP_RESET) begin
                        osc_period_reg    <= clamp_period({2'b0, init_period_reg});
                        osc_phase_reg     <= '0;
                        timer_started_reg <= 1'b0;
                    end else if (op_reg == OP_TICK && !timer_started_reg) begin
                        last_time_reg     <= time_reg;
                        timer_started_reg <= 1'b1;
                    end else begin
                    end
                end
                ST_PH_GO: last_time_reg <= time_reg;
                ST_PH_WAIT: if (div_done) osc_phase_reg <= osc_phase_reg + div_quot[15:0];
                ST_P4: begin
                    osc_phase_reg  <= neg_reg ? osc_phase_reg + dp1_reg
                                              : osc_phase_reg - dp1_reg;
                    osc_period_reg <= period_adj;
                end
                default: ;
            endcase
        end
    end

    // Work registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg   <= s_tuser;
            time_reg <= s_tdata[31:0];
            np_reg   <= s_tdata[55:32];
        end
        unique case (state_reg)
            ST_DISPATCH: begin
                before_reg   <= osc_phase_reg;
                valid_reg    <= (op_reg != OP_TICK);
                pulse_en_reg <= (op_reg == OP_TICK) || (op_reg == OP_ONSET);
            end
            ST_CR_GO: quad_reg <= ph_rnd[15:14];
            ST_CR_WAIT: begin
                m_reg    <= 18'(19'sd65536 - 19'(cos_v));
                smag_reg <= sin_v[17] ? 17'(-sin_v) : sin_v[16:0];
                neg_reg  <= sin_v[17];
            end
            ST_T3: t_reg <= t_sum[47:24];
            ST_Z2: begin
                z_reg    <= mul_p[45:16];
                term_reg <= ONE_Q30;
                sum_reg  <= 33'(ONE_Q30);
                n_reg    <= 4'd1;
            end
            // Accumulate one series term, alternating sign
            ST_ED_WAIT: begin
                term_reg <= {1'b0, term_q};
                sum_reg  <= n_reg[0] ? sum_reg - {3'b0, term_q}
                                     : sum_reg + {3'b0, term_q};
                n_reg    <= n_reg + 4'd1;
            end
            ST_EX: begin
                if (t_reg[23:16] >= 8'd31) begin
                    u_reg <= '0;
                    d_reg <= 32'(ONE_Q30);
                end else begin
                    u_reg <= sum_c >> t_reg[20:16];
                    d_reg <= 32'(ONE_Q30) + 32'(sum_c >> t_reg[20:16]);
                end
            end
            ST_Q_WAIT: if (div_done) q_reg <= div_quot[17:0];
            ST_S_WAIT: if (div_done) sech_reg <= div_quot[16:0];
            ST_F3: fmag_reg <= f_sum[47:32];
            ST_P2: dp1_reg <= p2_sum[23:8];
            ST_EMIT: begin
                if (out_free) begin
                    m_tdata_reg <= {pulse, (valid_reg ? osc_period_reg : 23'd0),
                                    osc_phase_reg};
                    m_tuser_reg <= valid_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // Period stays within its legal range
    a_period_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (osc_period_reg >= PERIOD_MIN) && (osc_period_reg <= PERIOD_MAX))
        else $error("period out of range");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_PH_WAIT || state_reg == ST_Q_WAIT ||
                      state_reg == ST_S_WAIT))
        else $error("divider done outside a wait state");

    // CORDIC finishes only while the sequencer waits for it
    a_cordic_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cr_done |-> (state_reg == ST_CR_WAIT))
        else $error("cordic done outside its wait state");

    // A result is loaded only from the emit state
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside emit");
`endif

endmodule

/* tb/tb_nonlinear_oscillator_beat_tracker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Beat tracker testbench
// Drives onset, tick, load and reset items with random gaps, tracks the
// expected phase, period and pulse with an independent fixed-point tracker,
// and compares every result item field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_nonlinear_oscillator_beat_tracker;
    import nobt_pkg::*;

    localparam int           TABLE_BITS  = 10;
    localparam int           IDLE_LIMIT  = 6000;
    localparam int           SETTLE      = 700;
    localparam logic [3:0]   CFG_UNUSED  = 4'd15;
    localparam longint       P_LO        = 204800;
    localparam longint       P_HI        = 6144000;
    localparam longint       ANGLE_STEP[16] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic [15:0] phase;
        logic [22:0] period;
        logic        valid;
        logic        pulse;
    } beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [22:0] cfg_data = '0;

    // Tracker state and register copies
    logic [15:0] trk_phase;
    logic [22:0] trk_period;
    logic [31:0] trk_last;
    logic        trk_started;
    logic [22:0] reg_init;
    logic [11:0] reg_gamma;
    logic [8:0]  reg_phase_gain;
    logic [8:0]  reg_period_gain;

    beat_t  beats_pending[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     no_gaps = 0;
    logic [31:0] now_ms = 0;

    nonlinear_oscillator_beat_tracker #(.TRIG_TABLE_BITS(TABLE_BITS)) u_top (.*);

    always #5 aclk = ~aclk;

    // Pick a gap length: mostly short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 94) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [22:0] clamp_to_range(input longint unsigned p);
        if (p < P_LO) return 23'(P_LO);
        if (p > P_HI) return 23'(P_HI);
        return 23'(p);
    endfunction

    function automatic longint round_q16(input longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 65536) r = 65536;
        if (r < -65536) r = -65536;
        return r;
    endfunction

    // Quantized phase to sine and cosine, Q16
    function automatic void phase_sincos(input logic [15:0] ph, output longint s,
                                         output longint c);
        longint unsigned p;
        longint x, y, z, nx, sr, cr;
        int sh;
        sh = 16 - TABLE_BITS;
        p = ph;
        if (sh > 0) p = ((p + (64'd1 << (sh - 1))) >> sh) << sh;
        p = p & 64'hFFFF;
        x = 652032875;
        y = 0;
        z = longint'(p & 64'h3FFF) <<< 8;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ANGLE_STEP[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ANGLE_STEP[i];
            end
            x = nx;
        end
        cr = round_q16(x);
        sr = round_q16(y);
        case (p >> 14)
            0: begin s = sr;  c = cr;  end
            1: begin s = cr;  c = -sr; end
            2: begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr; end
        endcase
    endfunction

    // 2^(-t/65536) in Q30
    function automatic longint unsigned pow2_neg(input longint unsigned t);
        longint unsigned k, z, term;
        longint acc;
        k = t >> 16;
        if (k >= 31) return 0;
        z = ((t & 64'hFFFF) * 64'd744261118) >> 16;
        term = 64'd1 << 30;
        acc = longint'(64'd1 << 30);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * z) >> 30) / n;
            if (n % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        return longint'(acc) >> k;
    endfunction

    // Phase correction magnitude; neg set when it pulls the phase forward
    function automatic longint unsigned pull_mag(input logic [15:0] ph, output bit neg);
        longint s, c;
        longint unsigned m, t, u, d, q, sech, smag;
        phase_sincos(ph, s, c);
        m = longint'(65536 - c);
        t = (longint'(reg_gamma) * m * 2 * 94548 + (64'd1 << 23)) >> 24;
        u = pow2_neg(t);
        d = (64'd1 << 30) + u;
        q = ((4 * u) << 16) / d;
        sech = (q << 30) / d;
        neg = s < 0;
        smag = s < 0 ? -s : s;
        return (smag * sech * 10430 + (64'd1 << 31)) >> 32;
    endfunction

    function automatic void advance_by_time(input logic [31:0] t);
        logic [31:0] dt;
        longint unsigned inc;
        dt = t - trk_last;
        inc = ((longint'(dt) << 26) + trk_period / 2) / trk_period;
        trk_last = t;
        trk_phase = trk_phase + 16'(inc);
    endfunction

    // Apply one accepted item to the tracker and queue its result, if it has one
    function automatic void track_item(input nobt_op_t op, input logic [31:0] t,
                                       input logic [23:0] np);
        beat_t r;
        logic signed [15:0] old_ph, new_ph;
        longint unsigned fm, dp, acc;
        bit neg;
        old_ph = trk_phase;
        if (op == OP_LOAD || op == OP_RESET) begin
            trk_period = (op == OP_LOAD) ? clamp_to_range(np) : clamp_to_range(reg_init);
            trk_phase = 0;
            if (op == OP_RESET) trk_started = 0;
            r = '{16'd0, trk_period, 1'b1, 1'b0};
            beats_pending.push_back(r);
            return;
        end
        if (op == OP_TICK) begin
            if (!trk_started) begin
                trk_last = t;
                trk_started = 1;
                return;
            end
            advance_by_time(t);
            r.period = 0;
            r.valid = 0;
        end else begin
            advance_by_time(t);
            fm = pull_mag(trk_phase, neg);
            dp = (longint'(reg_phase_gain) * fm + 128) >> 8;
            trk_phase = neg ? trk_phase + 16'(dp) : trk_phase - 16'(dp);
            dp = (longint'(trk_period) * reg_period_gain * fm + (64'd1 << 23)) >> 24;
            if (neg) begin
                trk_period = (dp >= trk_period) ? 23'(P_LO)
                           : clamp_to_range(trk_period - dp);
            end else begin
                acc = trk_period + dp;
                trk_period = clamp_to_range(acc);
            end
            r.period = trk_period;
            r.valid = 1;
        end
        new_ph = trk_phase;
        r.phase = trk_phase;
        r.pulse = (new_ph == 0) || (old_ph < 0 && new_ph > 0);
        beats_pending.push_back(r);
    endfunction

    // Send one item, then update the tracker once it is accepted
    task automatic send_item(input nobt_op_t op, input logic [31:0] t,
                             input logic [23:0] np);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {np, t};
        do @(posedge aclk); while (!s_tready);
        track_item(op, t, np);
    endtask

    // Write one register once all pending results are out and the block is quiet
    task automatic write_reg(input logic [3:0] idx, input logic [22:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (beats_pending.size() == 0);
        repeat (SETTLE) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_INIT_PERIOD: reg_init = val;
            CFG_FIELD_WIDTH: reg_gamma = val[11:0];
            CFG_PHASE_GAIN:  reg_phase_gain = val[8:0];
            CFG_PERIOD_GAIN: reg_period_gain = val[8:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [22:0] ip, input logic [11:0] g,
                             input logic [8:0] pg, input logic [8:0] qg);
        write_reg(CFG_INIT_PERIOD, ip);
        write_reg(CFG_FIELD_WIDTH, 23'(g));
        write_reg(CFG_PHASE_GAIN, 23'(pg));
        write_reg(CFG_PERIOD_GAIN, 23'(qg));
    endtask

    // Extremes of every field, each op, first tick, onset before any tick
    task automatic test_directed();
        send_item(OP_RESET, 32'd0, 24'd0);
        send_item(OP_ONSET, 32'd700, 24'd0);
        send_item(OP_TICK, 32'd1000, 24'd0);
        send_item(OP_TICK, 32'd1250, 24'd0);
        send_item(OP_ONSET, 32'd1500, 24'd0);
        send_item(OP_LOAD, 32'hFFFF_FFFF, 24'd0);
        send_item(OP_LOAD, 32'd0, 24'hFF_FFFF);
        send_item(OP_LOAD, 32'd0, 24'd512000);
        send_item(OP_TICK, 32'hFFFF_FF00, 24'd0);
        send_item(OP_ONSET, 32'h0000_0100, 24'd0);
        send_item(OP_TICK, 32'h0000_0100, 24'd0);
        write_all(23'h7F_FFFF, 12'hFFF, 9'h1FF, 9'h1FF);
        write_reg(CFG_UNUSED, 23'h55_5555);
        send_item(OP_RESET, 32'd0, 24'd0);
        send_item(OP_TICK, 32'd5000, 24'd0);
        for (int i = 0; i < 5; i++) send_item(OP_ONSET, 32'd5000 + 130 * (i + 1), 24'd0);
        write_all(23'd0, 12'd2560, 9'd256, 9'd256);
        send_item(OP_RESET, 32'd0, 24'd0);
        send_item(OP_TICK, 32'd9000, 24'd0);
        send_item(OP_ONSET, 32'd9400, 24'd0);
        send_item(OP_ONSET, 32'd9900, 24'd0);
        now_ms = 32'd9900;
    endtask

    // Random item mix with mostly advancing times and occasional random jumps
    task automatic test_random_stream(input int n);
        nobt_op_t op;
        int r;
        logic [23:0] np;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            np = 24'($urandom);
            if (r < 45)      op = OP_ONSET;
            else if (r < 88) op = OP_TICK;
            else if (r < 95) op = OP_LOAD;
            else             op = OP_RESET;
            if ($urandom_range(0, 99) < 4) now_ms = $urandom;
            else now_ms = now_ms + $urandom_range(0, 2500);
            if (op == OP_LOAD && $urandom_range(0, 1))
                np = 24'($urandom_range(204800, 6144000));
            send_item(op, now_ms, np);
        end
    endtask

    // Stop sending until every pending result has arrived
    task automatic test_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (beats_pending.size() == 0);
    endtask

    // Sweep register settings, each with its own random stream
    task automatic test_config_sweep();
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: write_all(23'd1024000, 12'd0, 9'd0, 9'd0);
                1: write_all(23'd204800, 12'd2560, 9'd256, 9'd256);
                2: write_all(23'd6144000, 12'd0, 9'd256, 9'd0);
                3: write_all(23'($urandom), 12'($urandom), 9'($urandom), 9'($urandom));
                default: write_all(23'($urandom_range(204800, 6144000)),
                                   12'($urandom_range(0, 2560)),
                                   9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)));
            endcase
            no_gaps = (k % 3 == 1);
            test_random_stream(150);
            test_drain();
            no_gaps = 0;
            test_random_stream(100);
        end
    endtask

    // Check each result against the oldest pending expectation
    always @(posedge aclk) begin
        beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (beats_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: phase=%h period=%0d", m_tdata[15:0],
                             m_tdata[38:16]);
            end else begin
                e = beats_pending.pop_front();
                if (m_tdata[15:0] !== e.phase || m_tdata[38:16] !== e.period ||
                    m_tuser !== e.valid || m_tdata[39] !== e.pulse) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ph=%h per=%0d v=%0b p=%0b got ph=%h per=%0d v=%0b p=%0b",
                                 e.phase, e.period, e.valid, e.pulse, m_tdata[15:0],
                                 m_tdata[38:16], m_tuser, m_tdata[39]);
                end
            end
        end
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= (pick_gap() == 0);
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL nonlinear_oscillator_beat_tracker");
            $finish;
        end
    end

    initial begin
        reg_init = 23'd1024000;
        reg_gamma = 0;
        reg_phase_gain = 0;
        reg_period_gain = 0;
        trk_phase = 0;
        trk_period = 23'd1024000;
        trk_last = 0;
        trk_started = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_config_sweep();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (beats_pending.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (beats_pending.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("PASS nonlinear_oscillator_beat_tracker");
        end else begin
            $display("FAIL nonlinear_oscillator_beat_tracker");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/nobt_pkg.sv
hw/rtl/nobt_mul.sv
hw/rtl/nobt_div.sv
hw/rtl/nobt_cordic.sv
hw/rtl/nonlinear_oscillator_beat_tracker.sv
tb/tb_nonlinear_oscillator_beat_tracker.sv
